@@ design/kar_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kar_pkg;

  localparam int unsigned CfgWidth  = 10;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  typedef struct packed {
    logic down_pressed;
    logic up_pressed;
  } kar_in_t;

  typedef struct packed {
    logic [15:0] count_value;
    logic [2:0]  digit_select;
    logic [6:0]  segment_code;
    logic        stepped;
  } kar_out_t;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_down_ticks;
    logic [CfgWidth-1:0] debounce_up_ticks;
    logic [CfgWidth-1:0] hold_first_ticks;
    logic [CfgWidth-1:0] hold_second_ticks;
    logic [CfgWidth-1:0] hold_third_ticks;
    logic [CfgWidth-1:0] repeat_ticks;
  } kar_cfg_t;

  typedef enum logic [2:0] {
    REG_DEBOUNCE_DOWN = 3'd0,
    REG_DEBOUNCE_UP   = 3'd1,
    REG_HOLD_FIRST    = 3'd2,
    REG_HOLD_SECOND   = 3'd3,
    REG_HOLD_THIRD    = 3'd4,
    REG_REPEAT        = 3'd5
  } kar_reg_e;

  localparam kar_cfg_t CfgReset = '{
    debounce_down_ticks: 10'd15,
    debounce_up_ticks:   10'd45,
    hold_first_ticks:    10'd300,
    hold_second_ticks:   10'd300,
    hold_third_ticks:    10'd240,
    repeat_ticks:        10'd60
  };

  localparam logic [2:0] DIGIT_UNITS    = 3'd7;
  localparam logic [2:0] DIGIT_TENS     = 3'd6;
  localparam logic [2:0] DIGIT_HUNDREDS = 3'd5;

  function automatic logic [6:0] seg7(input logic [3:0] digit);
    logic [6:0] code;
    case (digit)
      4'd0:    code = 7'h3f;
      4'd1:    code = 7'h06;
      4'd2:    code = 7'h5b;
      4'd3:    code = 7'h4f;
      4'd4:    code = 7'h66;
      4'd5:    code = 7'h6d;
      4'd6:    code = 7'h7d;
      4'd7:    code = 7'h07;
      4'd8:    code = 7'h7f;
      4'd9:    code = 7'h6f;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ design/kar_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kar_ctrl #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned TIMER_WIDTH = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire kar_pkg::kar_in_t  item_i,
  input  wire kar_pkg::kar_cfg_t cfg_i,
  output kar_pkg::kar_out_t      res_o
);
  import kar_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_DEBOUNCE = 6'b000010,
    PH_HOLD1    = 6'b000100,
    PH_HOLD2    = 6'b001000,
    PH_HOLD3    = 6'b010000,
    PH_REPEAT   = 6'b100000
  } kar_phase_e;

  localparam logic [31:0] TimerMax = 32'((64'd1 << TIMER_WIDTH) - 64'd1);
  localparam logic [COUNT_WIDTH-1:0] CountReset = COUNT_WIDTH'(100);
  localparam logic [11:0] BcdReset = {4'd1, 4'd0, 4'd0};
  localparam logic [TIMER_WIDTH-1:0] TimerOne = TIMER_WIDTH'(1);

  function automatic logic [TIMER_WIDTH-1:0] load_wait(input logic [CfgWidth-1:0] n);
    logic [31:0] nx;
    nx = 32'(n);
    if (nx == 32'd0) nx = 32'd1;
    if (nx > TimerMax) nx = TimerMax;
    return nx[TIMER_WIDTH-1:0];
  endfunction

  function automatic logic [11:0] bcd_inc(input logic [11:0] b);
    logic [3:0] d0, d1, d2;
    d0 = b[3:0];
    d1 = b[7:4];
    d2 = b[11:8];
    if (d0 == 4'd9) begin
      d0 = 4'd0;
      if (d1 == 4'd9) begin
        d1 = 4'd0;
        d2 = (d2 == 4'd9) ? 4'd0 : d2 + 4'd1;
      end else begin
        d1 = d1 + 4'd1;
      end
    end else begin
      d0 = d0 + 4'd1;
    end
    return {d2, d1, d0};
  endfunction

  function automatic logic [11:0] bcd_dec(input logic [11:0] b);
    logic [3:0] d0, d1, d2;
    d0 = b[3:0];
    d1 = b[7:4];
    d2 = b[11:8];
    if (d0 == 4'd0) begin
      d0 = 4'd9;
      if (d1 == 4'd0) begin
        d1 = 4'd9;
        d2 = (d2 == 4'd0) ? 4'd9 : d2 - 4'd1;
      end else begin
        d1 = d1 - 4'd1;
      end
    end else begin
      d0 = d0 - 4'd1;
    end
    return {d2, d1, d0};
  endfunction

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [11:0]            bcd_q, bcd_d;
  kar_phase_e             phase_q, phase_d;
  logic                   up_q, up_d;
  logic [TIMER_WIDTH-1:0] wait_q, wait_d;
  logic [1:0]             pos_q, pos_d;

  logic                    cnt_nz;
  logic                    held;
  logic                    held_post;
  logic                    busy;
  logic                    step_try;
  logic                    step_ok;
  logic [1:0]              pos_eff;
  logic [3:0]              digit;
  logic [2:0]              sel;
  logic [COUNT_WIDTH+15:0] count_ext;

  assign cnt_nz = |count_q;
  assign held   = up_q ? item_i.up_pressed : (item_i.down_pressed & cnt_nz);
  // held as seen against the count after this tick's step
  assign held_post = up_q ? item_i.up_pressed :
                     (item_i.down_pressed & (count_q > COUNT_WIDTH'(1)));
  assign busy   = (phase_q == PH_DEBOUNCE) || (phase_q == PH_HOLD1) ||
                  (phase_q == PH_HOLD2) || (phase_q == PH_HOLD3) ||
                  (phase_q == PH_REPEAT);

  // sequencer
  always_comb begin
    phase_d  = phase_q;
    up_d     = up_q;
    wait_d   = wait_q;
    step_try = 1'b0;
    if (!busy) begin
      phase_d = PH_IDLE;
      if (item_i.down_pressed && cnt_nz) begin
        up_d    = 1'b0;
        phase_d = PH_DEBOUNCE;
        wait_d  = load_wait(cfg_i.debounce_down_ticks);
      end else if (item_i.up_pressed) begin
        up_d    = 1'b1;
        phase_d = PH_DEBOUNCE;
        wait_d  = load_wait(cfg_i.debounce_up_ticks);
      end
    end else if (wait_q > TimerOne) begin
      wait_d = wait_q - TimerOne;
    end else begin
      unique case (phase_q)
        PH_DEBOUNCE: begin
          step_try = held;
          phase_d  = PH_HOLD1;
          wait_d   = load_wait(cfg_i.hold_first_ticks);
        end
        PH_HOLD1: begin
          if (held) begin
            phase_d = PH_HOLD2;
            wait_d  = load_wait(cfg_i.hold_second_ticks);
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_HOLD2: begin
          step_try = 1'b1;
          if (held_post) begin
            phase_d = PH_HOLD3;
            wait_d  = load_wait(cfg_i.hold_third_ticks);
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_HOLD3: begin
          step_try = 1'b1;
          phase_d  = PH_REPEAT;
          wait_d   = load_wait(cfg_i.repeat_ticks);
        end
        PH_REPEAT: begin
          if (held) begin
            step_try = 1'b1;
            wait_d   = load_wait(cfg_i.repeat_ticks);
          end else begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
      if (phase_d == PH_IDLE) wait_d = '0;
    end
  end

  // counter with a bcd shadow of its three low decimal digits
  assign step_ok = step_try & (up_q | cnt_nz);

  always_comb begin
    count_d = count_q;
    bcd_d   = bcd_q;
    if (step_ok) begin
      if (up_q) begin
        count_d = count_q + COUNT_WIDTH'(1);
        bcd_d   = (&count_q) ? 12'd0 : bcd_inc(bcd_q);
      end else begin
        count_d = count_q - COUNT_WIDTH'(1);
        bcd_d   = bcd_dec(bcd_q);
      end
    end
  end

  // display scan
  assign pos_eff = (pos_q == 2'd3) ? 2'd0 : pos_q;
  assign pos_d   = (pos_eff == 2'd2) ? 2'd0 : pos_eff + 2'd1;

  always_comb begin
    case (pos_eff)
      2'd0: begin
        digit = bcd_d[3:0];
        sel   = DIGIT_UNITS;
      end
      2'd1: begin
        digit = bcd_d[7:4];
        sel   = DIGIT_TENS;
      end
      default: begin
        digit = bcd_d[11:8];
        sel   = DIGIT_HUNDREDS;
      end
    endcase
  end

  assign count_ext = {16'd0, count_d};

  always_comb begin
    res_o.count_value  = count_ext[15:0];
    res_o.digit_select = sel;
    res_o.segment_code = seg7(digit);
    res_o.stepped      = step_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
      bcd_q   <= BcdReset;
      phase_q <= PH_IDLE;
      up_q    <= 1'b0;
      wait_q  <= '0;
      pos_q   <= 2'd0;
    end else if (accept_i) begin
      count_q <= count_d;
      bcd_q   <= bcd_d;
      phase_q <= phase_d;
      up_q    <= up_d;
      wait_q  <= wait_d;
      pos_q   <= pos_d;
    end
  end

  a_idle_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (wait_q == '0))
    else $error("timer running while idle");

  a_busy_timer_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (wait_q != '0))
    else $error("timer empty during a sequence");

  a_step_moves_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && step_ok) |=> (count_q != $past(count_q)))
    else $error("step did not change the count");

endmodule

`default_nettype wire

@@ design/kar_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kar_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire kar_pkg::kar_out_t item_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output kar_pkg::kar_out_t      out_item_o
);
  import kar_pkg::*;

  kar_out_t out_q;
  kar_out_t skid_q;
  logic     out_valid_q;
  logic     skid_valid_q;
  logic     pop;

  assign pop = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (push_i) begin
      if (out_valid_q && !pop) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push_i) begin
      if (out_valid_q && !pop) skid_q <= item_i;
      else out_q <= item_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

@@ design/key_auto_repeat_counter.sv @@
// latency: a result is buffered in the cycle after its tick is accepted
// throughput: one tick per cycle when not stalled, one state update per tick
// a two-entry output buffer keeps input taken while one result waits downstream
// reset: count 100, sequencer idle, scan at units, registers at their defaults
`timescale 1ns / 1ps
`default_nettype none

module key_auto_repeat_counter #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned TIMER_WIDTH = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire kar_pkg::kar_in_t                in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output kar_pkg::kar_out_t                    out_item_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [kar_pkg::AddrWidth-1:0]   paddr,
  input  wire logic [kar_pkg::DataWidth-1:0]   pwdata,
  output logic [kar_pkg::DataWidth-1:0]        prdata,
  output logic                                 pready
);
  import kar_pkg::*;

  kar_cfg_t cfg_q;
  kar_out_t res;
  kar_reg_e reg_idx;
  logic     cfg_we;
  logic     accept;
  logic     buf_full;
  logic [CfgWidth-1:0] rd_val;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign reg_idx = kar_reg_e'(paddr[AddrWidth-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_DEBOUNCE_DOWN: cfg_q.debounce_down_ticks <= pwdata[CfgWidth-1:0];
        REG_DEBOUNCE_UP:   cfg_q.debounce_up_ticks   <= pwdata[CfgWidth-1:0];
        REG_HOLD_FIRST:    cfg_q.hold_first_ticks    <= pwdata[CfgWidth-1:0];
        REG_HOLD_SECOND:   cfg_q.hold_second_ticks   <= pwdata[CfgWidth-1:0];
        REG_HOLD_THIRD:    cfg_q.hold_third_ticks    <= pwdata[CfgWidth-1:0];
        REG_REPEAT:        cfg_q.repeat_ticks        <= pwdata[CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE_DOWN: rd_val = cfg_q.debounce_down_ticks;
      REG_DEBOUNCE_UP:   rd_val = cfg_q.debounce_up_ticks;
      REG_HOLD_FIRST:    rd_val = cfg_q.hold_first_ticks;
      REG_HOLD_SECOND:   rd_val = cfg_q.hold_second_ticks;
      REG_HOLD_THIRD:    rd_val = cfg_q.hold_third_ticks;
      REG_REPEAT:        rd_val = cfg_q.repeat_ticks;
      default:           rd_val = '0;
    endcase
  end

  assign prdata = DataWidth'(rd_val);

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i & ~buf_full;

  kar_ctrl #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_item_i),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  kar_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .item_i     (res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  a_full_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("second entry held with empty output");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted tick produced no result");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.digit_select == DIGIT_UNITS ||
                     out_item_o.digit_select == DIGIT_TENS ||
                     out_item_o.digit_select == DIGIT_HUNDREDS))
    else $error("bad digit select");

endmodule

`default_nettype wire
